// ===== rtl/mcbs_pkg.sv =====
// Package for the modular labelling search block.
// Holds sizes, action codes and shared types; no dependencies.
package mcbs_pkg;
  localparam int MaxVertices = 32;
  localparam int MaxDegree   = 32;
  localparam int MaxWindow   = 64;
  localparam int VW = $clog2(MaxVertices);
  localparam int DW = $clog2(MaxDegree);
  localparam int LW = $clog2(MaxWindow);
  localparam int SW = VW + DW;

  localparam logic [1:0] ActAdd    = 2'd0;
  localparam logic [1:0] ActClear  = 2'd1;
  localparam logic [1:0] ActSolve  = 2'd2;
  // Spare action code; an item that carries it is ignored.
  localparam logic [1:0] ActUnused = 2'd3;

  localparam logic [0:0] RegWindow = 1'd0;
  localparam logic [0:0] RegVcount = 1'd1;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] vertex;
    logic [4:0] neighbour;
    logic [5:0] weight;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [4:0] vertex_index;
    logic [5:0] label;
    logic       last;
  } out_item_t;
endpackage

// ===== rtl/mcbs_if.sv =====
// Valid/ready channel carrying one payload item.
// Depends on mcbs_pkg for the payload types.
interface mcbs_in_if import mcbs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mcbs_out_if import mcbs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/modular_coloring_backtrack_solver.sv =====
// Top level of the modular labelling search block: edge store and search sequencer.
// Depends on mcbs_pkg and the channel interfaces in mcbs_if.sv.
//
// An add-edge or clear item is handled in the idle state. A solve item passes a start
// state and then runs a depth-first search through a single shared adder and compare
// unit reading the edge memory: each edge check is a registered memory read followed
// by the compare, and each candidate label or back-up step is a pass through the
// candidate state. The run time is set by the number of candidates and edge checks
// the backtracking makes, then one reported vertex per cycle while the output is not
// stalled. The block takes no item while a search runs or while its results drain;
// the last result may still wait in the output register when the next item is taken.
// Edge slots are never cleared; a per-vertex degree count marks which are valid.
module modular_coloring_backtrack_solver import mcbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  mcbs_in_if.sink     in_ch,
  mcbs_out_if.source  out_ch
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_CAND  = 7'b0000100,
    S_READ  = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_FAIL  = 7'b1000000
  } state_t;

  state_t state;
  logic [6:0] window_size;
  logic [5:0] vertex_count;
  logic [DW:0] degree_count [MaxVertices];
  logic [LW-1:0] assignment [MaxVertices];
  logic [VW-1:0] edge_nb [MaxVertices*MaxDegree];
  logic [LW-1:0] edge_wt [MaxVertices*MaxDegree];
  logic [VW-1:0] rd_nb;
  logic [LW-1:0] rd_wt;
  logic [VW:0]   n;
  logic [VW-1:0] n_prev;
  logic [DW:0]   k;
  logic [VW:0]   nv;
  logic [6:0]    win;
  logic [LW:0]   cur;
  logic          out_valid;
  out_item_t     out_data;

  // Vertex that a back-up step returns to.
  assign n_prev = n[VW-1:0] - 1'b1;

  // Clamped search sizes.
  logic [6:0] win_c;
  logic [VW:0] nv_c;
  always_comb begin
    win_c = (window_size > 7'(MaxWindow)) ? 7'(MaxWindow) : window_size;
    if (vertex_count > 6'(MaxVertices)) nv_c = (VW+1)'(MaxVertices);
    else if (vertex_count < 6'd2) nv_c = (VW+1)'(1);
    else nv_c = (VW+1)'(vertex_count);
  end

  in_item_t it;
  logic acc, add_ok;
  assign it = in_ch.data;
  assign in_ch.ready = (state == S_IDLE);
  assign acc = in_ch.valid && in_ch.ready;
  assign add_ok = (it.neighbour < it.vertex) && (degree_count[it.vertex] < (DW+1)'(MaxDegree));

  // Edge memory: one write port, one registered read of the slot under test.
  always_ff @(posedge clk) begin
    if (acc && it.action == ActAdd && add_ok) begin
      edge_nb[{it.vertex, degree_count[it.vertex][DW-1:0]}] <= it.neighbour;
      edge_wt[{it.vertex, degree_count[it.vertex][DW-1:0]}] <= it.weight;
    end
    rd_nb <= edge_nb[{n[VW-1:0], k[DW-1:0]}];
    rd_wt <= edge_wt[{n[VW-1:0], k[DW-1:0]}];
  end

  // Shared check unit: one sum against the weight and the wrapped weight.
  logic [7:0] sum;
  logic clash;
  assign sum = 8'(cur) + 8'(assignment[rd_nb]);
  assign clash = (sum == 8'(rd_wt)) || (sum == 8'(rd_wt) + 8'(win));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= 7'd4;
      vertex_count <= 6'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        RegWindow: window_size <= cfg_data;
        RegVcount: vertex_count <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Search sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < MaxVertices; i++) begin
        degree_count[i] <= '0;
        assignment[i] <= '0;
      end
      n <= '0;
      k <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            case (it.action)
              ActAdd: if (add_ok) degree_count[it.vertex] <= degree_count[it.vertex] + 1'b1;
              ActClear: for (int i = 0; i < MaxVertices; i++) degree_count[i] <= '0;
              ActSolve: begin
                win <= win_c;
                nv <= nv_c;
                state <= S_START;
              end
              default: ;
            endcase
          end
        end
        S_START: begin
          assignment[0] <= '0;
          if (win == 7'd0) state <= S_FAIL;
          else if (nv == (VW+1)'(1)) begin
            n <= '0;
            state <= S_EMIT;
          end else begin
            n <= (VW+1)'(1);
            cur <= '0;
            state <= S_CAND;
          end
        end
        // Try label cur for vertex n, or back up when the labels are used up.
        S_CAND: begin
          k <= '0;
          if (7'(cur) >= win) begin
            if (n == (VW+1)'(1)) state <= S_FAIL;
            else begin
              n <= n - 1'b1;
              cur <= (LW+1)'(assignment[n_prev]) + 1'b1;
            end
          end else if (degree_count[n[VW-1:0]] == '0) begin
            assignment[n[VW-1:0]] <= cur[LW-1:0];
            if (n + 1'b1 >= nv) begin
              n <= '0;
              state <= S_EMIT;
            end else begin
              n <= n + 1'b1;
              cur <= '0;
            end
          end else state <= S_READ;
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (clash) begin
            cur <= cur + 1'b1;
            state <= S_CAND;
          end else if (k + 1'b1 >= degree_count[n[VW-1:0]]) begin
            assignment[n[VW-1:0]] <= cur[LW-1:0];
            if (n + 1'b1 >= nv) begin
              n <= '0;
              state <= S_EMIT;
            end else begin
              n <= n + 1'b1;
              cur <= '0;
              state <= S_CAND;
            end
          end else begin
            k <= k + 1'b1;
            state <= S_READ;
          end
        end
        // Report labels, one vertex per item.
        S_EMIT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_data.found <= 1'b1;
            out_data.vertex_index <= n[VW-1:0];
            out_data.label <= assignment[n[VW-1:0]];
            out_data.last <= (n + 1'b1 == nv);
            n <= n + 1'b1;
            if (n + 1'b1 == nv) state <= S_IDLE;
          end
        end
        S_FAIL: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_data <= '{found: 1'b0, vertex_index: '0, label: '0, last: 1'b1};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ch.ready && !(state == S_EMIT || state == S_FAIL))
        out_valid <= 1'b0;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;
endmodule

// ===== rtl/mcbs_checker.sv =====
// Port-level checker for the labelling search block, bound to the top level.
// Depends on mcbs_pkg.
module mcbs_checker import mcbs_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("output item dropped");
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.last) else $error("failure item not last");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.label == '0) else $error("failure label nonzero");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> !in_ready) else $error("ready during result burst");
  a_first_v0: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found && out_data.vertex_index == '0 |-> out_data.label == '0)
    else $error("vertex 0 not labelled 0");
endmodule

bind modular_coloring_backtrack_solver mcbs_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
